[hw/rtl/chebyshev_waveshaper_core_macros.svh]
// ----------------------------------------------------------------------------
// Chebyshev waveshaper assertion macros
// Shorthand for the concurrent checks in the waveshaper RTL. The using module
// must have clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CHEBYSHEV_WAVESHAPER_CORE_MACROS_SVH
`define CHEBYSHEV_WAVESHAPER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset
`define CWV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define CWV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cwv_pkg.sv]
// ----------------------------------------------------------------------------
// Chebyshev waveshaper package
// Orders, fixed-point types and the pipeline record shared by the RTL files.
// ----------------------------------------------------------------------------
`default_nettype none

package cwv_pkg;

  // Number of polynomial terms evaluated, and gains carried per item
  localparam int ORDER      = 6;
  localparam int GAIN_COUNT = 6;

  // Polynomial values are Q2.15, clamped to [-1.0, +1.0]
  localparam int T_MAX = 32768;
  localparam int T_MIN = -32768;

  typedef logic signed [15:0] q15_t;    // Q1.15 sample or gain
  typedef logic signed [16:0] tval_t;   // Q2.15 polynomial value
  typedef logic signed [18:0] acc_t;    // Q4.15 running sum

  typedef q15_t [GAIN_COUNT-1:0] gain_vec_t;

  // One item in flight through the stages
  typedef struct packed {
    q15_t      x;
    tval_t     t_prev;
    tval_t     t_cur;
    acc_t      acc;
    gain_vec_t gains;
    logic      last;
  } pipe_t;

  // One finished result
  typedef struct packed {
    acc_t sample;
    logic last;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/cwv_if.sv]
// ----------------------------------------------------------------------------
// Chebyshev waveshaper stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cwv_in_if;
  logic               valid;
  logic               ready;
  cwv_pkg::q15_t      sample_in;
  cwv_pkg::q15_t      gain_one;
  cwv_pkg::q15_t      gain_two;
  cwv_pkg::q15_t      gain_three;
  cwv_pkg::q15_t      gain_four;
  cwv_pkg::q15_t      gain_five;
  cwv_pkg::q15_t      gain_six;
  logic               frame_last;

  modport source (
    output valid, sample_in, gain_one, gain_two, gain_three,
           gain_four, gain_five, gain_six, frame_last,
    input  ready
  );
  modport sink (
    input  valid, sample_in, gain_one, gain_two, gain_three,
           gain_four, gain_five, gain_six, frame_last,
    output ready
  );
endinterface

interface cwv_out_if;
  logic               valid;
  logic               ready;
  cwv_pkg::acc_t      sample_out;
  logic               frame_last_out;

  modport source (
    output valid, sample_out, frame_last_out,
    input  ready
  );
  modport sink (
    input  valid, sample_out, frame_last_out,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/chebyshev_waveshaper_core.sv]
// ----------------------------------------------------------------------------
// Chebyshev waveshaper core
// Sixth-order Chebyshev waveshaper: sum of gain_k * Tk(x) over k = 1..6.
//
//   Channel  Dir  Handshake      Payload
//   in_ch    in   valid/ready    sample_in, gain_one..gain_six, frame_last
//   out_ch   out  valid/ready    sample_out (Q4.15), frame_last_out
//
// One item per cycle is accepted while the output side drains. The pipeline
// has one stage per polynomial term, each holding one recurrence
// multiplier and one gain multiplier, then the output register.
// Reset clears the valid bits only; the datapath needs no clearing.
// An output stall fills a one-item skid register; in_ch.ready drops only
// while that register is full, and the whole pipeline holds meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chebyshev_waveshaper_core_macros.svh"

module chebyshev_waveshaper_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cwv_in_if.sink      in_ch,
  cwv_out_if.source   out_ch
);

  logic                  pipe_en;
  cwv_pkg::pipe_t        head_data;
  wire [cwv_pkg::ORDER:1] stage_valid;
  cwv_pkg::pipe_t        stage_data [1:cwv_pkg::ORDER];
  cwv_pkg::res_t         res;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  cwv_pkg::res_t         out_data_r;
  cwv_pkg::res_t         out_data_nxt;
  logic                  skid_valid_r;
  logic                  skid_valid_nxt;
  cwv_pkg::res_t         skid_data_r;
  cwv_pkg::res_t         skid_data_nxt;

  // Advance every stage unless the skid register holds an item
  assign pipe_en     = !skid_valid_r;
  assign in_ch.ready = pipe_en;

  // Seed the recurrence with T0 = 1.0 and T1 = x
  always_comb begin
    head_data        = '0;
    head_data.x      = in_ch.sample_in;
    head_data.t_prev = 17'(cwv_pkg::T_MAX);
    head_data.t_cur  = 17'(in_ch.sample_in);
    head_data.acc    = '0;
    head_data.gains  = {in_ch.gain_six, in_ch.gain_five, in_ch.gain_four,
                        in_ch.gain_three, in_ch.gain_two, in_ch.gain_one};
    head_data.last   = in_ch.frame_last;
  end

  // One stage per term
  for (genvar i = 0; i < cwv_pkg::ORDER; i++) begin : g_stage
    logic           src_valid;
    cwv_pkg::pipe_t src_data;
    cwv_pkg::q15_t  src_gain;

    if (i == 0) begin : g_head
      assign src_valid = in_ch.valid;
      assign src_data  = head_data;
    end else begin : g_body
      assign src_valid = stage_valid[i];
      assign src_data  = stage_data[i];
    end

    // Terms past the supplied gains weigh zero
    if (i < cwv_pkg::GAIN_COUNT) begin : g_gain
      assign src_gain = src_data.gains[i];
    end else begin : g_nogain
      assign src_gain = '0;
    end

    cwv_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (pipe_en),
      .in_valid  (src_valid),
      .in_data   (src_data),
      .gain      (src_gain),
      .out_valid (stage_valid[i+1]),
      .out_data  (stage_data[i+1])
    );
  end

  assign res.sample = stage_data[cwv_pkg::ORDER].acc;
  assign res.last   = stage_data[cwv_pkg::ORDER].last;

  // Output register with skid: take the finished item, park it if stalled
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_ch.ready) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (stage_valid[cwv_pkg::ORDER]) begin
      if (!out_valid_r || out_ch.ready) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.sample_out     = out_data_r.sample;
  assign out_ch.frame_last_out = out_data_r.last;

  // A parked item always sits behind a full output register
  `CWV_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r, "skid full with output empty")

  // A held pipeline keeps every stage valid bit
  `CWV_ASSERT_NEXT(a_pipe_hold, !pipe_en, $stable(stage_valid), "stage valid moved during stall")

  // A finished result that meets a stalled output fills the skid
  `CWV_ASSERT_NEXT(a_skid_fill, !skid_valid_r && stage_valid[cwv_pkg::ORDER] && out_valid_r && !out_ch.ready, skid_valid_r, "stalled result not parked")

  // A taken result with nothing behind it empties the output
  `CWV_ASSERT_NEXT(a_out_drain, out_valid_r && out_ch.ready && !skid_valid_r && !stage_valid[cwv_pkg::ORDER], !out_valid_r, "output valid without item")

endmodule

`default_nettype wire

[hw/rtl/cwv_stage.sv]
// ----------------------------------------------------------------------------
// Chebyshev waveshaper pipeline stage
// Adds gain * T(n) to the running sum and forms T(n+1) = 2x*T(n) - T(n-1),
// clamped to [-1, +1]. One register stage, advanced by a shared enable.
// ----------------------------------------------------------------------------
`default_nettype none

module cwv_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire cwv_pkg::pipe_t  in_data,
  input  wire cwv_pkg::q15_t   gain,
  output logic                 out_valid,
  output cwv_pkg::pipe_t       out_data
);

  logic signed [32:0] rec_prod;
  logic signed [19:0] rec_diff;
  cwv_pkg::tval_t     t_next;
  logic signed [32:0] term_prod;
  cwv_pkg::acc_t      acc_next;
  cwv_pkg::pipe_t     data_nxt;
  logic               valid_r;
  cwv_pkg::pipe_t     data_r;

  // Recurrence: floor(x * T(n) / 2^14) - T(n-1), then clamp
  assign rec_prod = 33'(in_data.x) * 33'(in_data.t_cur);
  assign rec_diff = 20'($signed(rec_prod[32:14])) - 20'(in_data.t_prev);

  always_comb begin
    if (rec_diff > 20'(cwv_pkg::T_MAX)) begin
      t_next = 17'(cwv_pkg::T_MAX);
    end else if (rec_diff < 20'(cwv_pkg::T_MIN)) begin
      t_next = 17'(cwv_pkg::T_MIN);
    end else begin
      t_next = 17'(rec_diff);
    end
  end

  // Weighted term: floor(gain * T(n) / 2^15), added to the sum
  assign term_prod = 33'(gain) * 33'(in_data.t_cur);
  assign acc_next  = in_data.acc + 19'($signed(term_prod[32:15]));

  // Shift the recurrence window forward
  always_comb begin
    data_nxt        = in_data;
    data_nxt.t_prev = in_data.t_cur;
    data_nxt.t_cur  = t_next;
    data_nxt.acc    = acc_next;
  end

  // Clear valid under reset, advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

[dv/tb_chebyshev_waveshaper_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chebyshev waveshaper core testbench
// Drives items of one sample and six gains into the core and checks every
// result against a cycle-free model of the order-six Chebyshev sum. The run
// covers directed extremes, random traffic with idle bursts on both sides,
// a long output stall, a drain pause and a final stretch at full rate.
// ----------------------------------------------------------------------------

module tb_chebyshev_waveshaper_core;

  import cwv_pkg::*;

  // One input item as the sender sees it; gain[0] is the first-order gain
  typedef struct packed {
    q15_t                  sample;
    q15_t [GAIN_COUNT-1:0] gain;
    logic                  last;
  } shaper_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cwv_in_if  in_ch ();
  cwv_out_if out_ch ();

  chebyshev_waveshaper_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Sums still owed by the core, oldest first
  res_t shaped_q[$];

  int unsigned err_count    = 0;
  int unsigned items_in     = 0;
  int unsigned results_out  = 0;
  int unsigned last_marks   = 0;
  int unsigned clamp_items  = 0;

  bit          tx_idle_on   = 1'b0;
  bit          rx_idle_on   = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned rx_gap_left  = 0;

  shaper_item_t seen_item;
  res_t         seen_res;
  res_t         due_res;
  bit           seen_clamp;

  always #2 clk = ~clk;

  // Weighted Chebyshev sum with floor products and clamped recurrence
  function automatic res_t shape_sample(shaper_item_t it, output bit clamped);
    longint x_v;
    longint t_prev;
    longint t_cur;
    longint t_next;
    longint sum;
    res_t   r;
    x_v     = longint'(it.sample);
    t_prev  = longint'(T_MAX);
    t_cur   = x_v;
    sum     = 0;
    clamped = 1'b0;
    for (int k = 1; k <= ORDER; k++) begin
      if (k > 1) begin
        t_next = ((x_v * t_cur) >>> 14) - t_prev;
        if (t_next > longint'(T_MAX)) begin
          t_next  = longint'(T_MAX);
          clamped = 1'b1;
        end else if (t_next < longint'(T_MIN)) begin
          t_next  = longint'(T_MIN);
          clamped = 1'b1;
        end
        t_prev = t_cur;
        t_cur  = t_next;
      end
      if (k <= GAIN_COUNT) begin
        sum += (longint'(it.gain[k-1]) * t_cur) >>> 15;
      end
    end
    r.sample = acc_t'(sum);
    r.last   = it.last;
    return r;
  endfunction

  // Pick a Q1.15 value: 0 full range, 1 close to an end or to zero, 2 small
  function automatic q15_t pick_q15(int unsigned mode);
    case (mode)
      1: begin
        case ($urandom_range(0, 3))
          0:       return q15_t'(32767 - $urandom_range(0, 15));
          1:       return q15_t'(-32768 + int'($urandom_range(0, 15)));
          2:       return q15_t'(int'($urandom_range(0, 16)) - 8);
          default: return ($urandom_range(0, 1) != 0) ? q15_t'(32767) : q15_t'(-32768);
        endcase
      end
      2:       return q15_t'(int'($urandom_range(0, 511)) - 256);
      default: return q15_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic shaper_item_t random_item();
    shaper_item_t it;
    it.sample = pick_q15($urandom_range(0, 2));
    for (int g = 0; g < GAIN_COUNT; g++) begin
      it.gain[g] = pick_q15(($urandom_range(0, 3) == 0) ? 1 : 0);
    end
    it.last = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  // Offer one item, optionally after an idle burst, and hold until taken
  task automatic send_item(shaper_item_t it);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.sample_in  <= it.sample;
    in_ch.gain_one   <= it.gain[0];
    in_ch.gain_two   <= it.gain[1];
    in_ch.gain_three <= it.gain[2];
    in_ch.gain_four  <= it.gain[3];
    in_ch.gain_five  <= it.gain[4];
    in_ch.gain_six   <= it.gain[5];
    in_ch.frame_last <= it.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait for every owed result; wait for a clock edge first so
  // the item taken at the current edge is already recorded
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (shaped_q.size() != 0) @(posedge clk);
  endtask

  // Extremes of sample and gains, each term alone, both marker values
  task automatic test_directed();
    q15_t         x_pts[9];
    shaper_item_t it;
    x_pts = '{-32768, -32767, -16384, -1, 0, 1, 16384, 23170, 32767};
    foreach (x_pts[i]) begin
      it.sample = x_pts[i];
      it.gain   = {GAIN_COUNT{q15_t'(32767)}};
      it.last   = i[0];
      send_item(it);
    end
    it.sample = q15_t'(-32768);
    it.gain   = {GAIN_COUNT{q15_t'(-32768)}};
    it.last   = 1'b1;
    send_item(it);
    it.sample = q15_t'(32767);
    send_item(it);
    it.gain   = {q15_t'(-32768), q15_t'(32767), q15_t'(-32768),
                 q15_t'(32767), q15_t'(-32768), q15_t'(32767)};
    it.last   = 1'b0;
    send_item(it);
    it.sample = q15_t'(-32767);
    send_item(it);
    // Isolate each order at a value where the recurrence drifts
    for (int k = 0; k < GAIN_COUNT; k++) begin
      it.sample  = q15_t'(32767 - k);
      it.gain    = '0;
      it.gain[k] = q15_t'(-32768);
      it.last    = (k == GAIN_COUNT - 1);
      send_item(it);
    end
    wait_results_done();
  endtask

  task automatic test_random_traffic(int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  // Hold the output long enough that the core fills and stalls its input
  task automatic test_output_hold();
    hold_request = 1'b1;
    repeat (48) send_item(random_item());
    wait_results_done();
  endtask

  // Pause the sender until the core has drained, then resume
  task automatic test_sender_pause();
    repeat (30) send_item(random_item());
    wait_results_done();
    repeat (20) send_item(random_item());
  endtask

  // Both sides at full rate for the closing stretch
  task automatic test_full_rate(int unsigned count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_item(random_item());
  endtask

  // Result side: long hold on request, otherwise random stall bursts when enabled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = 300;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      rx_gap_left = $urandom_range(1, 14) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Check each result against the oldest owed sum, then record new items
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_out++;
        if (shaped_q.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing owed: expected none, %s %0d last=%0b",
                   $time, "actual sample_out=", out_ch.sample_out,
                   out_ch.frame_last_out);
        end else begin
          due_res = shaped_q.pop_front();
          if (out_ch.sample_out !== due_res.sample) begin
            err_count++;
            $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                     $time, due_res.sample, out_ch.sample_out);
          end
          if (out_ch.frame_last_out !== due_res.last) begin
            err_count++;
            $display("%0t: frame_last_out mismatch: expected %0b, actual %0b",
                     $time, due_res.last, out_ch.frame_last_out);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen_item.sample  = in_ch.sample_in;
        seen_item.gain[0] = in_ch.gain_one;
        seen_item.gain[1] = in_ch.gain_two;
        seen_item.gain[2] = in_ch.gain_three;
        seen_item.gain[3] = in_ch.gain_four;
        seen_item.gain[4] = in_ch.gain_five;
        seen_item.gain[5] = in_ch.gain_six;
        seen_item.last    = in_ch.frame_last;
        seen_res = shape_sample(seen_item, seen_clamp);
        shaped_q.insert(shaped_q.size(), seen_res);
        items_in++;
        if (seen_item.last) last_marks++;
        if (seen_clamp) clamp_items++;
      end
    end
  end

  // Hard stop well past the slowest correct run
  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results owed", $time, shaped_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.sample_in  = '0;
    in_ch.gain_one   = '0;
    in_ch.gain_two   = '0;
    in_ch.gain_three = '0;
    in_ch.gain_four  = '0;
    in_ch.gain_five  = '0;
    in_ch.gain_six   = '0;
    in_ch.frame_last = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_directed();
    test_random_traffic(500);
    test_output_hold();
    test_sender_pause();
    test_random_traffic(300);
    test_full_rate(300);

    // Drain, then give the pipeline time to show any extra result
    wait_results_done();
    repeat (ORDER + 8) @(posedge clk);

    $display("Covered %0d items and %0d results, %0d frame-last marks,",
             items_in, results_out, last_marks);
    $display("%0d items with recurrence clamping, idle bursts, long stall and drain pause.",
             clamp_items);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/cwv_pkg.sv
hw/rtl/cwv_if.sv
hw/rtl/cwv_stage.sv
hw/rtl/chebyshev_waveshaper_core.sv
dv/tb_chebyshev_waveshaper_core.sv
